@@ rtl/ipidgs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipidgs_pkg
// Shared widths, register reset values and register indexes for the
// incremental PID controller with gain switching.
// ----------------------------------------------------------------------------
package ipidgs_pkg;

  localparam int PV_W       = 32;   // process value, signed Q16.16
  localparam int ERR_W      = 32;   // saturated error, signed Q16.16
  localparam int SP_W       = 31;   // setpoint / min setpoint, unsigned Q15.16
  localparam int GAIN_W     = 20;   // gains, unsigned Q4.16
  localparam int ACC_W      = 48;   // accumulator, signed Q32.16
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SP_W-1:0]   SETPOINT_RST     = SP_W'(0);
  localparam logic [GAIN_W-1:0] GAIN_P_RST       = GAIN_W'(52429);
  localparam logic [GAIN_W-1:0] GAIN_I_RST       = GAIN_W'(13107);
  localparam logic [GAIN_W-1:0] GAIN_D_RST       = GAIN_W'(655);
  localparam logic [GAIN_W-1:0] GAIN_P_FAR_RST   = GAIN_W'(131072);
  localparam logic [SP_W-1:0]   MIN_SETPOINT_RST = SP_W'(10486);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT     = 3'd0,
    CFG_GAIN_P       = 3'd1,
    CFG_GAIN_I       = 3'd2,
    CFG_GAIN_D       = 3'd3,
    CFG_GAIN_P_FAR   = 3'd4,
    CFG_MIN_SETPOINT = 3'd5
  } cfg_reg_t;

endpackage

@@ rtl/incremental_pid_gain_switch_core.sv @@
`timescale 1ns / 1ps
// Path: an accepted item waits in the input register and moves to the result
//   register when the output side is not stalled.
// Throughput: one item per cycle unless the output side stalls; error, gain
//   products and accumulate are one pass from input to result register.
// Reset: synchronous, active high; empties both stages, clears the error history
//   and accumulator, and loads the register reset values.
// ----------------------------------------------------------------------------
// incremental_pid_gain_switch_core
// Velocity-form PID on one measured sample per item, with far/near gain
// switching and a saturating Q32.16 drive accumulator.
// ----------------------------------------------------------------------------
module incremental_pid_gain_switch_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ipidgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ipidgs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ipidgs_pkg::PV_W-1:0]     process_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ipidgs_pkg::ACC_W-1:0]    drive_value,
  output logic                                   updated,
  output logic                                   far_mode
);

  // configuration
  logic [ipidgs_pkg::SP_W-1:0]   setpoint;
  logic [ipidgs_pkg::GAIN_W-1:0] gain_p;
  logic [ipidgs_pkg::GAIN_W-1:0] gain_i;
  logic [ipidgs_pkg::GAIN_W-1:0] gain_d;
  logic [ipidgs_pkg::GAIN_W-1:0] gain_p_far;
  logic [ipidgs_pkg::SP_W-1:0]   min_setpoint;

  // input stage
  logic                                s1_valid;
  logic signed [ipidgs_pkg::PV_W-1:0]  s1_pv;

  // controller state
  logic signed [ipidgs_pkg::ERR_W-1:0] last_error;
  logic signed [ipidgs_pkg::ERR_W-1:0] prior_error;
  logic signed [ipidgs_pkg::ACC_W-1:0] accumulator;

  // datapath
  logic                 run;
  logic                 far;
  logic                 advance;
  logic signed [32:0]   diff;
  logic signed [33:0]   diff2;
  logic signed [33:0]   sp_ext;
  logic signed [31:0]   err;
  logic signed [32:0]   pe;
  logic signed [33:0]   de;
  logic [ipidgs_pkg::GAIN_W-1:0] gp_sel;
  logic [ipidgs_pkg::GAIN_W-1:0] gd_sel;
  logic signed [20:0]   gp_s;
  logic signed [20:0]   gi_s;
  logic signed [20:0]   gd_s;
  logic signed [53:0]   prod_p;
  logic signed [52:0]   prod_i;
  logic signed [54:0]   prod_d;
  logic signed [55:0]   sum;
  logic signed [39:0]   inc;
  logic signed [48:0]   acc_sum;
  logic signed [ipidgs_pkg::ACC_W-1:0] accumulator_next;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || !out_valid || out_ready;
  assign run       = setpoint >= min_setpoint;

  always_comb begin
    diff   = $signed({2'b00, setpoint}) - $signed({s1_pv[31], s1_pv});
    diff2  = {diff, 1'b0};
    sp_ext = $signed({3'b000, setpoint});
    far    = diff2 >= sp_ext;

    if (diff[32] != diff[31]) begin
      err = diff[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      err = diff[31:0];
    end

    pe = 33'(err) - 33'(last_error);
    de = 34'(err) - (34'(last_error) <<< 1) + 34'(prior_error);

    gp_sel = far ? gain_p_far : gain_p;
    gd_sel = far ? '0 : gain_d;
    gp_s   = $signed({1'b0, gp_sel});
    gi_s   = $signed({1'b0, gain_i});
    gd_s   = $signed({1'b0, gd_sel});

    prod_p = 54'(pe) * 54'(gp_s);
    prod_i = 53'(err) * 53'(gi_s);
    prod_d = 55'(de) * 55'(gd_s);

    // round half up on the Q.32 sum, then drop to Q.16
    sum = 56'(prod_p) + 56'(prod_i) + 56'(prod_d) + 56'sd32768;
    inc = sum[55:16];

    acc_sum = 49'(accumulator) + 49'(inc);
    if (acc_sum[48] != acc_sum[47]) begin
      accumulator_next = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      accumulator_next = acc_sum[47:0];
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= ipidgs_pkg::SETPOINT_RST;
      gain_p       <= ipidgs_pkg::GAIN_P_RST;
      gain_i       <= ipidgs_pkg::GAIN_I_RST;
      gain_d       <= ipidgs_pkg::GAIN_D_RST;
      gain_p_far   <= ipidgs_pkg::GAIN_P_FAR_RST;
      min_setpoint <= ipidgs_pkg::MIN_SETPOINT_RST;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      last_error   <= '0;
      prior_error  <= '0;
      accumulator  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (ipidgs_pkg::cfg_reg_t'(cfg_index))
          ipidgs_pkg::CFG_SETPOINT:     setpoint     <= cfg_data[ipidgs_pkg::SP_W-1:0];
          ipidgs_pkg::CFG_GAIN_P:       gain_p       <= cfg_data[ipidgs_pkg::GAIN_W-1:0];
          ipidgs_pkg::CFG_GAIN_I:       gain_i       <= cfg_data[ipidgs_pkg::GAIN_W-1:0];
          ipidgs_pkg::CFG_GAIN_D:       gain_d       <= cfg_data[ipidgs_pkg::GAIN_W-1:0];
          ipidgs_pkg::CFG_GAIN_P_FAR:   gain_p_far   <= cfg_data[ipidgs_pkg::GAIN_W-1:0];
          ipidgs_pkg::CFG_MIN_SETPOINT: min_setpoint <= cfg_data[ipidgs_pkg::SP_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
        if (run) begin
          prior_error <= last_error;
          last_error  <= err;
          accumulator <= accumulator_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pv <= process_value;
    end
    if (advance) begin
      drive_value <= run ? accumulator_next : accumulator;
      updated     <= run;
      far_mode    <= run && far;
    end
  end

endmodule

@@ rtl/ipidgs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipidgs_checker
// Port-level checks for the incremental PID core, bound to the top level.
// ----------------------------------------------------------------------------
module ipidgs_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   cfg_valid,
  input logic                                   cfg_ready,
  input logic [ipidgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [ipidgs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic signed [ipidgs_pkg::PV_W-1:0]     process_value,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [ipidgs_pkg::ACC_W-1:0]    drive_value,
  input logic                                   updated,
  input logic                                   far_mode
);

  // drive value of the last delivered item
  logic signed [ipidgs_pkg::ACC_W-1:0] last_drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_drive <= '0;
    end else if (out_valid && out_ready) begin
      last_drive <= drive_value;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_value)
      && $stable(updated) && $stable(far_mode))
    else $error("stalled result changed");

  a_far_needs_update: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (updated || !far_mode))
    else $error("far mode flagged on a skipped item");

  a_skip_keeps_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && !updated |-> drive_value == last_drive)
    else $error("drive value moved on a skipped item");

endmodule

bind incremental_pid_gain_switch_core ipidgs_checker u_ipidgs_checker (.*);

@@ tb/incremental_pid_gain_switch_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pid_gain_switch_checker
// Watches the config, sample and result channels of the PID core. It keeps
// its own copy of the registers, error history and drive accumulator, predicts
// each result as samples are accepted and compares results field by field in
// order. It reports the number of failures and the results still outstanding.
// ----------------------------------------------------------------------------
module incremental_pid_gain_switch_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [ipidgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ipidgs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [ipidgs_pkg::PV_W-1:0]     process_value,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [ipidgs_pkg::ACC_W-1:0]    drive_value,
  input  logic                                   updated,
  input  logic                                   far_mode,
  output int                                     fail_count,
  output int                                     pending
);

  localparam longint ERR_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint ERR_LO = -64'sh0000_0000_8000_0000;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic signed [ipidgs_pkg::ACC_W-1:0] drive_value;
    logic                                updated;
    logic                                far_mode;
  } pid_result_t;

  logic [ipidgs_pkg::SP_W-1:0]         setpoint_q, min_setpoint_q;
  logic [ipidgs_pkg::GAIN_W-1:0]       gain_p_q, gain_i_q, gain_d_q, gain_p_far_q;
  logic signed [ipidgs_pkg::ERR_W-1:0] last_err, prior_err;
  logic signed [ipidgs_pkg::ACC_W-1:0] drive_acc;
  pid_result_t                         drive_expected[$];
  int                                  errors = 0;
  int                                  queued = 0;

  assign fail_count = errors;
  assign pending    = queued;

  function automatic pid_result_t predict_drive(
    input logic signed [ipidgs_pkg::PV_W-1:0] pv
  );
    longint      sp, diff, e, pe, de, sum, inc, acc_next;
    pid_result_t r;
    r.updated  = 1'b0;
    r.far_mode = 1'b0;
    if (setpoint_q >= min_setpoint_q) begin
      sp   = longint'(setpoint_q);
      diff = sp - longint'(pv);
      e    = (diff > ERR_HI) ? ERR_HI : (diff < ERR_LO) ? ERR_LO : diff;
      pe   = e - longint'(last_err);
      de   = e - 2 * longint'(last_err) + longint'(prior_err);
      r.far_mode = (2 * diff >= sp);
      if (r.far_mode) begin
        sum = pe * longint'(gain_p_far_q) + e * longint'(gain_i_q);
      end else begin
        sum = pe * longint'(gain_p_q) + e * longint'(gain_i_q) + de * longint'(gain_d_q);
      end
      // single rounding, half toward +inf
      inc      = (sum + 64'sd32768) >>> 16;
      acc_next = longint'(drive_acc) + inc;
      if (acc_next > ACC_HI) acc_next = ACC_HI;
      if (acc_next < ACC_LO) acc_next = ACC_LO;
      prior_err = last_err;
      last_err  = e[ipidgs_pkg::ERR_W-1:0];
      drive_acc = acc_next[ipidgs_pkg::ACC_W-1:0];
      r.updated = 1'b1;
    end
    r.drive_value = drive_acc;
    return r;
  endfunction

  always @(posedge clk) begin
    pid_result_t want;
    if (rst) begin
      setpoint_q     = ipidgs_pkg::SETPOINT_RST;
      gain_p_q       = ipidgs_pkg::GAIN_P_RST;
      gain_i_q       = ipidgs_pkg::GAIN_I_RST;
      gain_d_q       = ipidgs_pkg::GAIN_D_RST;
      gain_p_far_q   = ipidgs_pkg::GAIN_P_FAR_RST;
      min_setpoint_q = ipidgs_pkg::MIN_SETPOINT_RST;
      last_err       = '0;
      prior_err      = '0;
      drive_acc      = '0;
      drive_expected.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (drive_expected.size() == 0) begin
          $error("unexpected result: drive_value %0d updated %0b far_mode %0b",
                 drive_value, updated, far_mode);
          errors++;
        end else begin
          want = drive_expected.pop_front();
          if (drive_value !== want.drive_value) begin
            $error("drive_value: expected %0d, got %0d", want.drive_value, drive_value);
            errors++;
          end
          if (updated !== want.updated) begin
            $error("updated: expected %0b, got %0b", want.updated, updated);
            errors++;
          end
          if (far_mode !== want.far_mode) begin
            $error("far_mode: expected %0b, got %0b", want.far_mode, far_mode);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ipidgs_pkg::CFG_SETPOINT:     setpoint_q     = cfg_data[ipidgs_pkg::SP_W-1:0];
          ipidgs_pkg::CFG_GAIN_P:       gain_p_q       = cfg_data[ipidgs_pkg::GAIN_W-1:0];
          ipidgs_pkg::CFG_GAIN_I:       gain_i_q       = cfg_data[ipidgs_pkg::GAIN_W-1:0];
          ipidgs_pkg::CFG_GAIN_D:       gain_d_q       = cfg_data[ipidgs_pkg::GAIN_W-1:0];
          ipidgs_pkg::CFG_GAIN_P_FAR:   gain_p_far_q   = cfg_data[ipidgs_pkg::GAIN_W-1:0];
          ipidgs_pkg::CFG_MIN_SETPOINT: min_setpoint_q = cfg_data[ipidgs_pkg::SP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        drive_expected.push_back(predict_drive(process_value));
      end
    end
    queued <= drive_expected.size();
  end

endmodule

@@ tb/tb_incremental_pid_gain_switch_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_incremental_pid_gain_switch_core
// Drives the PID core with directed samples around the setpoint, the far/near
// boundary, the error limits and the disabled state, then random samples
// under a series of register settings with random idling on both sides.
// Checking is done by the checker beside the core.
// ----------------------------------------------------------------------------
module tb_incremental_pid_gain_switch_core;

  localparam int CLK_HALF    = 5;
  localparam int STALL_LIMIT = 2000;
  localparam int SET_ITEMS   = 50;
  localparam int TAIL_CYCLES = 4;

  localparam logic [ipidgs_pkg::CFG_IDX_W-1:0]   CFG_SPARE_A = 3'd6;
  localparam logic [ipidgs_pkg::CFG_IDX_W-1:0]   CFG_SPARE_B = 3'd7;
  localparam logic signed [ipidgs_pkg::PV_W-1:0] PV_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [ipidgs_pkg::PV_W-1:0] PV_MIN      = 32'sh8000_0000;
  localparam logic [ipidgs_pkg::CFG_DATA_W-1:0]  SP_MAX      = 32'h7FFF_FFFF;
  localparam logic [ipidgs_pkg::CFG_DATA_W-1:0]  GAIN_MAX    = 32'h000F_FFFF;
  localparam logic [ipidgs_pkg::CFG_DATA_W-1:0]  SP_100      = 32'h0064_0000;

  logic                                clk           = 1'b0;
  logic                                rst           = 1'b1;
  logic                                cfg_valid     = 1'b0;
  logic [ipidgs_pkg::CFG_IDX_W-1:0]    cfg_index     = '0;
  logic [ipidgs_pkg::CFG_DATA_W-1:0]   cfg_data      = '0;
  logic                                in_valid      = 1'b0;
  logic signed [ipidgs_pkg::PV_W-1:0]  process_value = '0;
  logic                                out_ready     = 1'b0;
  logic                                cfg_ready, in_ready, out_valid, updated, far_mode;
  logic signed [ipidgs_pkg::ACC_W-1:0] drive_value;
  int                                  fail_count, pending;

  int                          send_idle_pct = 0;
  int                          recv_idle_pct = 0;
  int                          stall_cycles  = 0;
  logic [ipidgs_pkg::SP_W-1:0] sp_now        = '0;

  incremental_pid_gain_switch_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .process_value(process_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive_value(drive_value), .updated(updated), .far_mode(far_mode)
  );

  incremental_pid_gain_switch_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .process_value(process_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive_value(drive_value), .updated(updated), .far_mode(far_mode),
    .fail_count(fail_count), .pending(pending)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [ipidgs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ipidgs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [ipidgs_pkg::CFG_DATA_W-1:0] sp, gp, gi, gd, gpf,
                            msp);
    write_reg(ipidgs_pkg::CFG_SETPOINT, sp);
    write_reg(ipidgs_pkg::CFG_GAIN_P, gp);
    write_reg(ipidgs_pkg::CFG_GAIN_I, gi);
    write_reg(ipidgs_pkg::CFG_GAIN_D, gd);
    write_reg(ipidgs_pkg::CFG_GAIN_P_FAR, gpf);
    write_reg(ipidgs_pkg::CFG_MIN_SETPOINT, msp);
    cfg_valid <= 1'b0;
    sp_now = sp[ipidgs_pkg::SP_W-1:0];
  endtask

  task automatic send_item(input logic signed [ipidgs_pkg::PV_W-1:0] pv);
    int gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    process_value <= pv;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // samples near the target, near the far/near boundary, extremes, or anything
  function automatic logic signed [ipidgs_pkg::PV_W-1:0] rand_pv();
    longint s, v;
    s = longint'(sp_now);
    case ($urandom_range(3))
      0: v = longint'($urandom);
      1: v = s + longint'($urandom_range(8191)) - 4096;
      2: v = s - (s >>> 1) - (longint'($urandom_range(4)) - 2);
      default: begin
        case ($urandom_range(3))
          0: v = longint'(PV_MAX);
          1: v = longint'(PV_MIN);
          2: v = 0;
          default: v = s;
        endcase
      end
    endcase
    return v[ipidgs_pkg::PV_W-1:0];
  endfunction

  initial begin
    logic [ipidgs_pkg::CFG_DATA_W-1:0] sp_w, msp_w;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 70;

    // reset registers: setpoint below minimum, nothing regulates
    send_item(PV_MAX);
    send_item(PV_MIN);
    drain();

    set_config(SP_100, 32'd52429, 32'd13107, 32'd655, 32'd131072, 32'd10486);
    send_item('0);
    send_item(SP_100);
    send_item(SP_100 >> 1);
    send_item((SP_100 >> 1) + 1);
    send_item(PV_MAX);
    send_item(PV_MIN);
    send_item(SP_100 - 1);
    send_item(SP_100 + 1);
    drain();

    // all extremes, min equal to setpoint, error saturation
    set_config(SP_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, SP_MAX);
    send_item(PV_MIN);
    send_item(PV_MAX);
    send_item('0);
    send_item(PV_MIN);
    send_item(PV_MAX);
    drain();

    // zero setpoint with zero minimum, unused high bits set
    set_config(32'h8000_0000, 32'hFFF0_0000, 32'hFFF0_0000, 32'hFFF0_0000, 32'hFFF0_0000,
               32'h8000_0000);
    send_item('0);
    send_item(32'sd1);
    send_item(-32'sd1);
    send_item(PV_MIN);
    send_item(PV_MAX);
    drain();

    // writes past the register list, then minimum above setpoint
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    write_reg(ipidgs_pkg::CFG_MIN_SETPOINT, 32'd1);
    cfg_valid <= 1'b0;
    send_item(32'sd12345);
    send_item(PV_MIN);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 70 : 0;
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 29 : 0;
      for (int k = 0; k < 5; k++) begin
        case (k)
          0: begin
            sp_w  = $urandom;
            msp_w = $urandom_range(sp_w[ipidgs_pkg::SP_W-1:0]);
            set_config(sp_w, $urandom, $urandom, $urandom, $urandom, msp_w);
          end
          1: set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          2: set_config($urandom_range(32'h0010_0000), $urandom_range(32'h0003_0000),
                        $urandom_range(32'h0003_0000), $urandom_range(32'h0003_0000),
                        $urandom_range(32'h0003_0000), '0);
          3: begin
            sp_w  = $urandom_range(1) ? SP_MAX : '0;
            msp_w = $urandom_range(1) ? sp_w : '0;
            set_config(sp_w, $urandom_range(1) ? GAIN_MAX : '0,
                       $urandom_range(1) ? GAIN_MAX : '0,
                       $urandom_range(1) ? GAIN_MAX : '0,
                       $urandom_range(1) ? GAIN_MAX : '0, msp_w);
          end
          default: begin
            sp_w = $urandom;
            set_config(sp_w, $urandom, $urandom, $urandom, $urandom, sp_w);
          end
        endcase
        repeat (SET_ITEMS) send_item(rand_pv());
        drain();
      end
    end

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ incremental_pid_gain_switch_core.f @@
rtl/ipidgs_pkg.sv
rtl/incremental_pid_gain_switch_core.sv
rtl/ipidgs_checker.sv
tb/incremental_pid_gain_switch_checker.sv
tb/tb_incremental_pid_gain_switch_core.sv
